// ===== src/ddo_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the odometry core.
package ddo_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int ADDR_W = 3;

	localparam logic [23:0] MM_PER_COUNT_RST = 24'd2048;
	localparam logic [31:0] ANGLE_PER_MM_RST = 32'd8544674;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;

	typedef enum logic {
		REG_MM_PER_COUNT = 1'b0,
		REG_ANGLE_PER_MM = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DELTA,
		S_MUL1,
		S_PREP,
		S_MUL2,
		S_ANGLE,
		S_CORDIC,
		S_XYSET,
		S_MULXY,
		S_RATE,
		S_FINISH
	} state_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051E;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// ===== src/ddo_meas_if.sv =====
`timescale 1ns / 1ps
// Measurement channel: encoder counts and elapsed time.
interface ddo_meas_if;
	logic valid;
	logic ready;
	logic signed [31:0] left_position;
	logic signed [31:0] right_position;
	logic [15:0] elapsed_ms;

	modport source(output valid, left_position, right_position, elapsed_ms, input ready);
	modport sink(input valid, left_position, right_position, elapsed_ms, output ready);
endinterface

// ===== src/ddo_pose_if.sv =====
`timescale 1ns / 1ps
// Pose channel: position, heading and speeds.
interface ddo_pose_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] heading;
	logic signed [31:0] speed;
	logic signed [31:0] turn_rate;

	modport source(output valid, pos_x, pos_y, heading, speed, turn_rate, input ready);
	modport sink(input valid, pos_x, pos_y, heading, speed, turn_rate, output ready);
endinterface

// ===== src/differential_drive_odometry_core.sv =====
`timescale 1ns / 1ps
// Differential-drive odometry core: bit-serial multipliers, dividers and an iterative CORDIC.
// An item with elapsed_ms of zero goes straight to the finish state and returns the current
// pose unchanged. Any other item passes through a 24-step shift-add multiply for the wheel
// travel, a 32-step multiply by angle_per_mm, the CORDIC iterations and a 34-step multiply
// for the x and y steps. The 51-step speed and turn-rate dividers run alongside the CORDIC
// and the x and y multiply, and hold the sequencer when CORDIC_STEPS is below 16. One item
// is in work at a time; a finished item waits in the output register while the next one is
// taken, and a second finished item waits until that register is free.
module differential_drive_odometry_core #(
	parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	ddo_meas_if.sink meas,
	ddo_pose_if.source pose,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ddo_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	ddo_pkg::state_t st_q, st_d;
	logic [5:0] cnt_q;
	logic [5:0] div_cnt_q;
	logic div_busy_q;
	logic out_valid_q;
	logic load_out;
	logic cfg_wr;

	logic [23:0] mpc_q;
	logic [31:0] apm_q;

	logic [31:0] prev_l_q, prev_r_q;
	logic [31:0] acc_x_q, acc_y_q, acc_h_q;
	logic [31:0] spd_q, trn_q;

	logic [31:0] l_q, r_q;
	logic [15:0] ms_q;
	logic signed [32:0] sd_q, dd_q;
	logic [33:0] mplr_q, mply_q;
	logic signed [33:0] ps_acc_q, pd_acc_q;
	logic [23:0] ps_lo_q, pd_lo_q;
	logic signed [55:0] dist_q;
	logic signed [56:0] diff_q;
	logic [56:0] mag_q, p_acc_q;
	logic [31:0] p_lo_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic flip_q;
	logic signed [56:0] mcand_q;
	logic signed [57:0] xa_q, ya_q;
	logic [33:0] xlo_q, ylo_q;
	logic [50:0] sn_q, tn_q;
	logic [16:0] srem_q, trem_q;
	logic ssat_q, tsat_q, sneg_q, tneg_q;
	logic [31:0] ox_q, oy_q, oh_q, os_q, ot_q;

	logic [31:0] dl, dr;
	logic signed [34:0] s_sum, d_sum;
	logic [56:0] psum, pdif, dist_t;
	logic [57:0] p_sum;
	logic [88:0] prod;
	logic [48:0] sp49;
	logic [31:0] ang, ang2;
	logic [55:0] dmag;
	logic [50:0] snum;
	logic signed [33:0] dx, dy, at;
	logic xy_last;
	logic signed [57:0] xadd, yadd;
	logic signed [58:0] x_sum, y_sum;
	logic [16:0] srem_sh, trem_sh;
	logic [17:0] strial, ttrial;
	logic [31:0] smag, tmag, spd_new, trn_new;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		case (ddo_pkg::reg_idx_t'(paddr[2]))
			ddo_pkg::REG_MM_PER_COUNT: prdata = {8'd0, mpc_q};
			ddo_pkg::REG_ANGLE_PER_MM: prdata = apm_q;
			default: prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpc_q <= ddo_pkg::MM_PER_COUNT_RST;
			apm_q <= ddo_pkg::ANGLE_PER_MM_RST;
		end else if (cfg_wr) begin
			case (ddo_pkg::reg_idx_t'(paddr[2]))
				ddo_pkg::REG_MM_PER_COUNT: mpc_q <= pwdata[23:0];
				ddo_pkg::REG_ANGLE_PER_MM: apm_q <= pwdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ddo_pkg::S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		meas.ready = 1'b0;
		load_out = 1'b0;
		case (st_q)
			ddo_pkg::S_IDLE: begin
				meas.ready = 1'b1;
				if (meas.valid) begin
					st_d = (meas.elapsed_ms == 16'd0) ? ddo_pkg::S_FINISH : ddo_pkg::S_DELTA;
				end
			end
			ddo_pkg::S_DELTA: st_d = ddo_pkg::S_MUL1;
			ddo_pkg::S_MUL1: if (cnt_q == 6'd23) st_d = ddo_pkg::S_PREP;
			ddo_pkg::S_PREP: st_d = ddo_pkg::S_MUL2;
			ddo_pkg::S_MUL2: if (cnt_q == 6'd31) st_d = ddo_pkg::S_ANGLE;
			ddo_pkg::S_ANGLE: st_d = ddo_pkg::S_CORDIC;
			ddo_pkg::S_CORDIC: if (cnt_q == 6'(CORDIC_STEPS - 1)) st_d = ddo_pkg::S_XYSET;
			ddo_pkg::S_XYSET: st_d = ddo_pkg::S_MULXY;
			ddo_pkg::S_MULXY: if (cnt_q == 6'd33) st_d = ddo_pkg::S_RATE;
			ddo_pkg::S_RATE: if (!div_busy_q) st_d = ddo_pkg::S_FINISH;
			ddo_pkg::S_FINISH: begin
				if (!out_valid_q || pose.ready) begin
					load_out = 1'b1;
					st_d = ddo_pkg::S_IDLE;
				end
			end
			default: st_d = ddo_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= (st_d != st_q) ? 6'd0 : cnt_q + 6'd1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pose.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// serial multiplier steps
	assign dl = l_q - prev_l_q;
	assign dr = r_q - prev_r_q;
	assign s_sum = {ps_acc_q[33], ps_acc_q} + (mplr_q[0] ? {{2{sd_q[32]}}, sd_q} : 35'sd0);
	assign d_sum = {pd_acc_q[33], pd_acc_q} + (mplr_q[0] ? {{2{dd_q[32]}}, dd_q} : 35'sd0);
	assign psum = {ps_acc_q[32:0], ps_lo_q};
	assign pdif = {pd_acc_q[32:0], pd_lo_q};
	assign dist_t = psum + {56'd0, psum[56]};
	assign p_sum = {1'b0, p_acc_q} + (mplr_q[0] ? {1'b0, mag_q} : 58'd0);
	assign prod = {p_acc_q, p_lo_q};
	assign sp49 = diff_q[56] ? (49'd0 - prod[48:0]) : prod[48:0];
	assign ang = acc_h_q + sp49[48:17];
	assign ang2 = (ang[31] ^ ang[30]) ? ang + ddo_pkg::HALF_TURN : ang;
	assign dmag = dist_q[55] ? 56'd0 - 56'(dist_q) : 56'(dist_q);
	assign snum = {dmag[40:0], 10'd0} - {6'd0, dmag[40:0], 4'd0} - {7'd0, dmag[40:0], 3'd0};

	// CORDIC step
	assign dx = cy_q >>> cnt_q[4:0];
	assign dy = cx_q >>> cnt_q[4:0];
	assign at = {2'b00, ddo_pkg::atan_lut(cnt_q[4:0])};

	assign xy_last = (cnt_q == 6'd33);
	assign xadd = mplr_q[0] ? {mcand_q[56], mcand_q} : 58'sd0;
	assign yadd = mply_q[0] ? {mcand_q[56], mcand_q} : 58'sd0;
	assign x_sum = xy_last ? {xa_q[57], xa_q} - {xadd[57], xadd}
		: {xa_q[57], xa_q} + {xadd[57], xadd};
	assign y_sum = xy_last ? {ya_q[57], ya_q} - {yadd[57], yadd}
		: {ya_q[57], ya_q} + {yadd[57], yadd};

	always_ff @(posedge clk) begin
		case (st_q)
			ddo_pkg::S_IDLE: begin
				l_q <= meas.left_position;
				r_q <= meas.right_position;
				ms_q <= meas.elapsed_ms;
			end
			ddo_pkg::S_DELTA: begin
				sd_q <= {dl[31], dl} + {dr[31], dr};
				dd_q <= {dr[31], dr} - {dl[31], dl};
				mplr_q <= {10'd0, mpc_q};
				ps_acc_q <= 34'sd0;
				pd_acc_q <= 34'sd0;
			end
			ddo_pkg::S_MUL1: begin
				ps_acc_q <= s_sum[34:1];
				pd_acc_q <= d_sum[34:1];
				ps_lo_q <= {s_sum[0], ps_lo_q[23:1]};
				pd_lo_q <= {d_sum[0], pd_lo_q[23:1]};
				mplr_q <= {1'b0, mplr_q[33:1]};
			end
			ddo_pkg::S_PREP: begin
				dist_q <= dist_t[56:1];
				diff_q <= pdif;
				mag_q <= pdif[56] ? 57'd0 - pdif : pdif;
				p_acc_q <= 57'd0;
				mplr_q <= {2'd0, apm_q};
			end
			ddo_pkg::S_MUL2: begin
				p_acc_q <= p_sum[57:1];
				p_lo_q <= {p_sum[0], p_lo_q[31:1]};
				mplr_q <= {1'b0, mplr_q[33:1]};
			end
			ddo_pkg::S_ANGLE: begin
				flip_q <= ang[31] ^ ang[30];
				cz_q <= {{2{ang2[31]}}, ang2};
				cx_q <= ddo_pkg::CORDIC_GAIN;
				cy_q <= 34'sd0;
			end
			ddo_pkg::S_CORDIC: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + at;
				end
			end
			ddo_pkg::S_XYSET: begin
				mcand_q <= flip_q ? 57'sd0 - {dist_q[55], dist_q} : {dist_q[55], dist_q};
				mplr_q <= cx_q;
				mply_q <= cy_q;
				xa_q <= 58'sd0;
				ya_q <= 58'sd0;
			end
			ddo_pkg::S_MULXY: begin
				xa_q <= x_sum[58:1];
				ya_q <= y_sum[58:1];
				xlo_q <= {x_sum[0], xlo_q[33:1]};
				ylo_q <= {y_sum[0], ylo_q[33:1]};
				mplr_q <= {1'b0, mplr_q[33:1]};
				mply_q <= {1'b0, mply_q[33:1]};
			end
			default: ;
		endcase
	end

	// restoring dividers for speed and turn rate
	assign srem_sh = {srem_q[15:0], sn_q[50]};
	assign trem_sh = {trem_q[15:0], tn_q[50]};
	assign strial = {1'b0, srem_sh} - {2'd0, ms_q};
	assign ttrial = {1'b0, trem_sh} - {2'd0, ms_q};

	always_ff @(posedge clk) begin
		if (st_q == ddo_pkg::S_ANGLE) begin
			sn_q <= snum;
			tn_q <= {4'd0, prod[62:16]};
			srem_q <= 17'd0;
			trem_q <= 17'd0;
			ssat_q <= (dmag[55:41] != 15'd0);
			tsat_q <= (prod[88:63] != 26'd0);
			sneg_q <= dist_q[55];
			tneg_q <= diff_q[56];
		end else if (div_busy_q) begin
			if (!strial[17]) begin
				srem_q <= strial[16:0];
				sn_q <= {sn_q[49:0], 1'b1};
			end else begin
				srem_q <= srem_sh;
				sn_q <= {sn_q[49:0], 1'b0};
			end
			if (!ttrial[17]) begin
				trem_q <= ttrial[16:0];
				tn_q <= {tn_q[49:0], 1'b1};
			end else begin
				trem_q <= trem_sh;
				tn_q <= {tn_q[49:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q <= 6'd0;
		end else if (st_q == ddo_pkg::S_ANGLE) begin
			div_busy_q <= 1'b1;
			div_cnt_q <= 6'd0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + 6'd1;
			if (div_cnt_q == 6'd50) div_busy_q <= 1'b0;
		end
	end

	assign smag = (ssat_q || sn_q[50:31] != 20'd0) ? ddo_pkg::SAT_MAX : sn_q[31:0];
	assign tmag = (tsat_q || tn_q[50:31] != 20'd0) ? ddo_pkg::SAT_MAX : tn_q[31:0];
	assign spd_new = sneg_q ? 32'd0 - smag : smag;
	assign trn_new = tneg_q ? 32'd0 - tmag : tmag;

	// odometry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= 32'd0;
			prev_r_q <= 32'd0;
			acc_x_q <= 32'd0;
			acc_y_q <= 32'd0;
			acc_h_q <= 32'd0;
			spd_q <= 32'd0;
			trn_q <= 32'd0;
		end else begin
			if (st_q == ddo_pkg::S_DELTA) begin
				prev_l_q <= l_q;
				prev_r_q <= r_q;
			end
			if (st_q == ddo_pkg::S_ANGLE) begin
				acc_h_q <= acc_h_q + sp49[47:16];
			end
			if (st_q == ddo_pkg::S_RATE && !div_busy_q) begin
				acc_x_q <= acc_x_q + {xa_q[27:0], xlo_q[33:30]};
				acc_y_q <= acc_y_q + {ya_q[27:0], ylo_q[33:30]};
				spd_q <= spd_new;
				trn_q <= trn_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			ox_q <= acc_x_q;
			oy_q <= acc_y_q;
			oh_q <= acc_h_q;
			os_q <= spd_q;
			ot_q <= trn_q;
		end
	end

	assign pose.valid = out_valid_q;
	assign pose.pos_x = ox_q;
	assign pose.pos_y = oy_q;
	assign pose.heading = oh_q;
	assign pose.speed = os_q;
	assign pose.turn_rate = ot_q;

endmodule

// ===== src/ddo_checker.sv =====
`timescale 1ns / 1ps
// Port checks for the odometry core and their binding.
module ddo_checker (
	input logic clk,
	input logic arst_n,
	input logic meas_valid,
	input logic meas_ready,
	input logic pose_valid,
	input logic pose_ready,
	input logic [31:0] pose_pos_x,
	input logic [31:0] pose_heading,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ddo_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	a_pose_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && !pose_ready |=> pose_valid)
		else $error("pose item dropped while stalled");

	a_pose_stable: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && !pose_ready |=> $stable(pose_pos_x) && $stable(pose_heading))
		else $error("pose payload changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas_ready |=> !meas_ready)
		else $error("second item taken before first finished");

	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite) ##1 (paddr == $past(paddr)) |->
		(paddr[2] ? (prdata == $past(pwdata)) : (prdata == {8'd0, $past(pwdata[23:0])})))
		else $error("register readback mismatch");

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (
	.clk(clk),
	.arst_n(arst_n),
	.meas_valid(meas.valid),
	.meas_ready(meas.ready),
	.pose_valid(pose.valid),
	.pose_ready(pose.ready),
	.pose_pos_x(pose.pos_x),
	.pose_heading(pose.heading),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata)
);

// ===== dv/differential_drive_odometry_core_test.sv =====
`timescale 1ns / 1ps
// Odometry core test: directed table, then random encoder items checked against a predictor.
module differential_drive_odometry_core_test;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] hdg;
		logic [31:0] spd;
		logic [31:0] rate;
	} pose_t;

	typedef struct {
		logic [31:0] l;
		logic [31:0] r;
		logic [15:0] ms;
		bit typed;
		pose_t want;
	} meas_row_t;

	localparam logic [31:0] ARCTAN [0:31] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};
	localparam int SETTLE_CYCLES = 160;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ddo_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ddo_meas_if meas();
	ddo_pose_if pose();

	differential_drive_odometry_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.meas(meas.sink),
		.pose(pose.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	logic [23:0] odo_mm_per_count;
	logic [31:0] odo_angle_per_mm;
	logic [31:0] odo_prev_l, odo_prev_r;
	logic [31:0] odo_x, odo_y, odo_hdg, odo_spd, odo_rate;

	pose_t pending_poses[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic [31:0] sent_l = '0, sent_r = '0;
	meas_row_t directed_rows[$];

	initial begin
		meas.valid = 1'b0;
		meas.left_position = '0;
		meas.right_position = '0;
		meas.elapsed_ms = '0;
		pose.ready = 1'b0;
	end

	function automatic logic [31:0] sat_signed(bit neg, longint unsigned mag);
		longint v;
		v = (mag > 64'h7fff_ffff) ? 64'h7fff_ffff : longint'(mag);
		if (neg) v = -v;
		return v[31:0];
	endfunction

	function automatic void rotate_unit(logic [31:0] ang, output longint c, output longint s);
		bit flip;
		longint vx, vy, vz, dx, dy;
		flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		if (flip) ang = ang + ddo_pkg::HALF_TURN;
		vx = 652032874;
		vy = 0;
		vz = longint'($signed(ang));
		for (int i = 0; i < ddo_pkg::CORDIC_STEPS_DEF; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vz >= 0) begin
				vx = vx - dx; vy = vy + dy; vz = vz - longint'(ARCTAN[i]);
			end else begin
				vx = vx + dx; vy = vy - dy; vz = vz + longint'(ARCTAN[i]);
			end
		end
		c = flip ? -vx : vx;
		s = flip ? -vy : vy;
	endfunction

	function automatic pose_t advance_odometry(logic [31:0] l, logic [31:0] r, logic [15:0] ms);
		longint lmm, rmm, travel, diff, c, s, px, py;
		longint unsigned prod, mag, hi, lo, ums;
		logic [31:0] dl, dr;
		if (ms != 0) begin
			ums = longint'(ms);
			dl = l - odo_prev_l;
			dr = r - odo_prev_r;
			lmm = longint'($signed(dl)) * longint'(odo_mm_per_count);
			rmm = longint'($signed(dr)) * longint'(odo_mm_per_count);
			travel = (lmm + rmm) / 2;
			diff = rmm - lmm;
			prod = longint'(diff) * longint'(odo_angle_per_mm);
			rotate_unit(odo_hdg + prod[48:17], c, s);
			px = travel * c;
			py = travel * s;
			odo_x = odo_x + px[61:30];
			odo_y = odo_y + py[61:30];
			odo_hdg = odo_hdg + prod[47:16];
			mag = (travel < 0) ? -travel : travel;
			if (mag >= (64'd1 << 41)) odo_spd = sat_signed(travel < 0, 64'h7fff_ffff);
			else odo_spd = sat_signed(travel < 0, mag * 1000 / ums);
			mag = (diff < 0) ? -diff : diff;
			hi = (mag >> 32) * longint'(odo_angle_per_mm);
			lo = (mag & 64'hffff_ffff) * longint'(odo_angle_per_mm);
			if (hi >= (64'd1 << 31)) odo_rate = sat_signed(diff < 0, 64'h7fff_ffff);
			else odo_rate = sat_signed(diff < 0, ((hi << 16) + (lo >> 16)) / ums);
			odo_prev_l = l;
			odo_prev_r = r;
		end
		return '{x: odo_x, y: odo_y, hdg: odo_hdg, spd: odo_spd, rate: odo_rate};
	endfunction

	task automatic apb_cycle(bit wr, ddo_pkg::reg_idx_t idx, logic [31:0] data,
		output logic [31:0] rd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_geometry(logic [23:0] mpc, logic [31:0] apm);
		logic [31:0] rd;
		apb_cycle(1'b1, ddo_pkg::REG_MM_PER_COUNT, {8'h00, mpc}, rd);
		apb_cycle(1'b1, ddo_pkg::REG_ANGLE_PER_MM, apm, rd);
		odo_mm_per_count = mpc;
		odo_angle_per_mm = apm;
		apb_cycle(1'b0, ddo_pkg::REG_MM_PER_COUNT, '0, rd);
		if (rd[23:0] !== mpc) begin
			mismatches++;
			if (mismatches <= 10) $display("mm_per_count readback %h, want %h", rd, mpc);
		end
		apb_cycle(1'b0, ddo_pkg::REG_ANGLE_PER_MM, '0, rd);
		if (rd !== apm) begin
			mismatches++;
			if (mismatches <= 10) $display("angle_per_mm readback %h, want %h", rd, apm);
		end
	endtask

	task automatic send_meas(logic [31:0] l, logic [31:0] r, logic [15:0] ms, bit typed,
		pose_t want);
		pose_t got;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			meas.valid <= 1'b0;
			@(posedge clk);
		end
		meas.valid <= 1'b1;
		meas.left_position <= l;
		meas.right_position <= r;
		meas.elapsed_ms <= ms;
		do @(posedge clk); while (!meas.ready);
		got = advance_odometry(l, r, ms);
		pending_poses.push_back(typed ? want : got);
		sent_l = l;
		sent_r = r;
	endtask

	task automatic drain_and_settle();
		meas.valid <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_meas(int count);
		logic [31:0] l, r;
		logic [15:0] ms;
		int span;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 80) begin
				span = ($urandom_range(0, 9) == 0) ? 1000000 : 3000;
				l = sent_l + $urandom_range(0, 2 * span) - span;
				r = sent_r + $urandom_range(0, 2 * span) - span;
				ms = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 50));
			end else begin
				l = $urandom;
				r = $urandom;
				case ($urandom_range(0, 3))
					0: ms = 16'd0;
					1: ms = 16'hffff;
					2: ms = 16'd1;
					default: ms = 16'($urandom);
				endcase
			end
			send_meas(l, r, ms, 1'b0, '0);
		end
	endtask

	task automatic add_row(logic [31:0] l, logic [31:0] r, logic [15:0] ms, bit typed = 1'b0);
		directed_rows.push_back('{l: l, r: r, ms: ms, typed: typed, want: '0});
	endtask

	always @(posedge clk) begin
		pose_t got, want;
		pose.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		if (pose.valid && pose.ready) begin
			got = '{x: pose.pos_x, y: pose.pos_y, hdg: pose.heading, spd: pose.speed,
				rate: pose.turn_rate};
			if (pending_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected pose %h", got);
			end else begin
				want = pending_poses.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pose x %h/%h y %h/%h hdg %h/%h spd %h/%h rate %h/%h (got/want)",
							got.x, want.x, got.y, want.y, got.hdg, want.hdg,
							got.spd, want.spd, got.rate, want.rate);
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		odo_mm_per_count = ddo_pkg::MM_PER_COUNT_RST;
		odo_angle_per_mm = ddo_pkg::ANGLE_PER_MM_RST;
		{odo_prev_l, odo_prev_r, odo_x, odo_y, odo_hdg, odo_spd, odo_rate} = '0;

		add_row(32'd0, 32'd0, 16'd0, 1'b1);
		add_row(32'd5, -32'sd5, 16'd0, 1'b1);
		add_row(32'd100, 32'd100, 16'd1);
		add_row(32'd100, 32'd100, 16'd0);
		add_row(32'h7fff_ffff, 32'h8000_0000, 16'd1);
		add_row(32'h8000_0000, 32'h7fff_ffff, 16'hffff);
		add_row(32'hffff_ffff, 32'hffff_ffff, 16'hffff);
		add_row(32'h0000_0000, 32'h0000_0000, 16'd7);
		add_row(-32'sd1000000, 32'd1000000, 16'd1);
		add_row(-32'sd1000000, 32'd1002000, 16'd10);
		add_row(-32'sd1000000, 32'd1004000, 16'd10);
		add_row(-32'sd1000000, 32'd1006000, 16'd10);
		add_row(-32'sd1000000, 32'd1008000, 16'd10);
		add_row(-32'sd990000, 32'd1018000, 16'd3);
		add_row(-32'sd980000, 32'd1028000, 16'd3);
		add_row(-32'sd970000, 32'd1038000, 16'd3);
		add_row(-32'sd960000, 32'd1048000, 16'd3);
		add_row(32'h5555_5555, 32'haaaa_aaaa, 16'h5555);
		add_row(32'haaaa_aaaa, 32'h5555_5555, 16'haaaa);
		add_row(32'h0000_0001, 32'h0000_0000, 16'd2);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 29;
		recv_idle_pct = 60;
		foreach (directed_rows[i])
			send_meas(directed_rows[i].l, directed_rows[i].r, directed_rows[i].ms,
				directed_rows[i].typed, directed_rows[i].want);
		random_meas(200);

		for (int ph = 0; ph < 5; ph++) begin
			drain_and_settle();
			case (ph)
				0: set_geometry(24'hff_ffff, 32'hffff_ffff);
				1: set_geometry(24'd1, 32'd1);
				2: set_geometry(24'd0, 32'd0);
				default: set_geometry(24'($urandom_range(1, 24'hff_ffff)), $urandom);
			endcase
			send_idle_pct = (ph % 3 == 0) ? 60 : (ph % 3 == 1) ? 0 : 29;
			recv_idle_pct = (ph % 3 == 0) ? 29 : (ph % 3 == 1) ? 0 : 60;
			random_meas(ph == 2 ? 100 : 235);
		end

		drain_and_settle();
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
src/ddo_pkg.sv
src/ddo_meas_if.sv
src/ddo_pose_if.sv
src/differential_drive_odometry_core.sv
src/ddo_checker.sv
dv/differential_drive_odometry_core_test.sv
